### design/orb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overwrite ring buffer package
// Shared sizes, codes, state type and the command, status and beat structs.
// ----------------------------------------------------------------------------
package orb_pkg;

  localparam int DEPTH      = 64;
  localparam int WORD_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int REQ_W      = 2;
  localparam int KIND_W     = 2;
  localparam int RMV_W      = 8;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LIST   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } orb_state_t;

  typedef struct packed {
    logic exec;
    logic start_list;
    logic rd_issue;
    logic list_push;
  } orb_cmd_t;

  typedef struct packed {
    logic list_req;
    logic can_push;
    logic more;
    logic pend_valid;
    logic pend_last;
  } orb_sts_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [WORD_WIDTH-1:0] element;
    logic [CNT_W-1:0]      occupancy;
    logic                  last;
  } orb_beat_t;

endpackage

### design/orb_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overwrite ring buffer request channel
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface orb_req_if;
  logic                            valid;
  logic                            ready;
  logic [orb_pkg::REQ_W-1:0]       req_type;
  logic [orb_pkg::WORD_WIDTH-1:0]  value;
  logic [orb_pkg::RMV_W-1:0]       remove_count;

  modport source (output valid, req_type, value, remove_count, input ready);
  modport sink (input valid, req_type, value, remove_count, output ready);
endinterface

### design/orb_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overwrite ring buffer response channel
// Valid/ready channel carrying one response beat.
// ----------------------------------------------------------------------------
interface orb_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [orb_pkg::KIND_W-1:0]      kind;
  logic [orb_pkg::WORD_WIDTH-1:0]  element;
  logic [orb_pkg::CNT_W-1:0]       occupancy;
  logic                            last;

  modport source (output valid, kind, element, occupancy, last, input ready);
  modport sink (input valid, kind, element, occupancy, last, output ready);
endinterface

### design/orb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overwrite ring buffer controller
// Accepts requests and sequences the read-out of a list request.
// ----------------------------------------------------------------------------
module orb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  orb_pkg::orb_sts_t sts,
  output orb_pkg::orb_cmd_t cmd
);
  import orb_pkg::*;

  orb_state_t state_r;
  orb_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.can_push && sts.list_req) begin
          state_nxt = ST_LIST;
        end
      end
      ST_LIST: begin
        if (sts.pend_valid && sts.can_push && sts.pend_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready       = sts.can_push;
        cmd.exec       = in_valid && sts.can_push && !sts.list_req;
        cmd.start_list = in_valid && sts.can_push && sts.list_req;
      end
      ST_LIST: begin
        cmd.list_push = sts.pend_valid && sts.can_push;
        cmd.rd_issue  = sts.more && (!sts.pend_valid || cmd.list_push);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### design/orb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overwrite ring buffer datapath
// Entry memory, ring pointers, capacity register and a two-beat output queue.
// ----------------------------------------------------------------------------
module orb_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [orb_pkg::REQ_W-1:0]       req_type,
  input  logic [orb_pkg::WORD_WIDTH-1:0]  value,
  input  logic [orb_pkg::RMV_W-1:0]       remove_count,
  input  logic                            cfg_wr_en,
  input  logic [orb_pkg::CNT_W-1:0]       cfg_wr_data,
  input  orb_pkg::orb_cmd_t               cmd,
  output orb_pkg::orb_sts_t               sts,
  orb_rsp_if.source                       out_if
);
  import orb_pkg::*;

  logic [WORD_WIDTH-1:0] mem [DEPTH];

  logic [PTR_W-1:0]      ptr_r, ptr_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      cap_r;
  logic [CNT_W-1:0]      eff_cap;
  logic [CNT_W-1:0]      cnt_inc;
  logic [CNT_W-1:0]      rd_cnt_r;
  logic [CNT_W-1:0]      rd_cnt_inc;
  logic [PTR_W-1:0]      tail;
  logic [PTR_W-1:0]      rd_addr;
  logic [WORD_WIDTH-1:0] rd_data_r;
  logic                  pend_valid_r;
  logic                  pend_last_r;

  orb_beat_t             q0_r, q1_r;
  logic [1:0]            fill_r;
  logic                  push;
  logic                  pop;
  orb_beat_t             push_beat;

  assign eff_cap    = (cap_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_r;
  assign cnt_inc    = count_r + CNT_W'(1);
  assign tail       = ptr_r + count_r[PTR_W-1:0];
  assign rd_addr    = ptr_r + rd_cnt_r[PTR_W-1:0];
  assign rd_cnt_inc = rd_cnt_r + CNT_W'(1);

  always_comb begin
    ptr_nxt   = ptr_r;
    count_nxt = count_r;
    if (cmd.exec) begin
      unique case (req_type)
        REQ_APPEND: begin
          if (count_r != CNT_W'(DEPTH)) begin
            if (cnt_inc > eff_cap) begin
              ptr_nxt = ptr_r + PTR_W'(1);
            end else begin
              count_nxt = cnt_inc;
            end
          end else begin
            ptr_nxt = ptr_r + PTR_W'(1);
          end
        end
        REQ_REMOVE: begin
          if (remove_count >= RMV_W'(count_r)) begin
            ptr_nxt   = ptr_r + count_r[PTR_W-1:0];
            count_nxt = '0;
          end else begin
            ptr_nxt   = ptr_r + remove_count[PTR_W-1:0];
            count_nxt = count_r - remove_count[CNT_W-1:0];
          end
        end
        default: begin
          ptr_nxt = ptr_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      count_r <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      ptr_r   <= ptr_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (req_type == REQ_APPEND)) begin
      mem[tail] <= value;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r     <= '0;
      pend_valid_r <= 1'b0;
      pend_last_r  <= 1'b0;
    end else begin
      if (cmd.start_list) begin
        rd_cnt_r     <= '0;
        pend_valid_r <= 1'b0;
      end else if (cmd.rd_issue) begin
        rd_cnt_r     <= rd_cnt_inc;
        pend_valid_r <= 1'b1;
        pend_last_r  <= (rd_cnt_inc == count_r);
      end else if (cmd.list_push) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    push_beat = '0;
    if (cmd.list_push) begin
      push_beat.kind      = KIND_ENTRY;
      push_beat.element   = rd_data_r;
      push_beat.occupancy = count_r;
      push_beat.last      = pend_last_r;
    end else begin
      push_beat.kind      = (req_type == REQ_LIST) ? KIND_EMPTY : KIND_ACK;
      push_beat.occupancy = count_nxt;
      push_beat.last      = 1'b1;
    end
  end

  assign push = cmd.exec || cmd.list_push;
  assign pop  = out_if.valid && out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      unique case (fill_r)
        2'd0: begin
          if (push) begin
            fill_r <= 2'd1;
          end
        end
        2'd1: begin
          if (push && !pop) begin
            fill_r <= 2'd2;
          end else if (pop && !push) begin
            fill_r <= 2'd0;
          end
        end
        2'd2: begin
          if (pop) begin
            fill_r <= 2'd1;
          end
        end
        default: fill_r <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (fill_r)
      2'd0: begin
        if (push) begin
          q0_r <= push_beat;
        end
      end
      2'd1: begin
        if (push && pop) begin
          q0_r <= push_beat;
        end else if (push) begin
          q1_r <= push_beat;
        end
      end
      2'd2: begin
        if (pop) begin
          q0_r <= q1_r;
        end
      end
      default: q0_r <= q0_r;
    endcase
  end

  assign out_if.valid     = (fill_r != 2'd0);
  assign out_if.kind      = q0_r.kind;
  assign out_if.element   = q0_r.element;
  assign out_if.occupancy = q0_r.occupancy;
  assign out_if.last      = q0_r.last;

  assign sts.list_req   = (req_type == REQ_LIST) && (count_r != '0);
  assign sts.can_push   = (fill_r != 2'd2);
  assign sts.more       = (rd_cnt_r != count_r);
  assign sts.pend_valid = pend_valid_r;
  assign sts.pend_last  = pend_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("Entry count exceeds the ring depth.");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> fill_r != 2'd2)
    else $error("Beat pushed into a full output queue.");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> rd_cnt_r < count_r)
    else $error("List read issued past the stored entries.");

  a_list_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_issue || cmd.list_push) |=> $stable(count_r) && $stable(ptr_r))
    else $error("Ring state changed during a list.");

  a_exec_beat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> fill_r != 2'd0)
    else $error("Executed request left no beat queued.");

endmodule

### design/overwrite_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overwrite ring buffer
// Bounded FIFO of 32-bit words whose oldest entry is overwritten at capacity.
// ----------------------------------------------------------------------------
// Requests arrive on in_if (valid/ready) and responses leave on out_if.
// An append or remove beat yields one acknowledge beat; a list beat yields
// one beat per stored word, oldest first, with last on the final one, or a
// single empty beat. Every response carries the occupancy after the request.
// An append, remove or empty list executes as it is accepted and its response
// is registered into the output queue, so these run at one request per cycle
// while the receiver keeps up. A list of N entries occupies the block until
// its last beat is queued, one memory read per entry through the single read
// port, and no request is taken meanwhile. Responses pass a two-beat output
// queue, so a stalled receiver holds off new requests only once it is full.
// The user must write the capacity register through cfg_wr_en and cfg_wr_data
// only while the block is idle; the block itself does not enforce this. Reset
// empties the ring and sets the capacity to 64; the entry memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module overwrite_ring_buffer (
  input  logic                       clk,
  input  logic                       rst_n,
  orb_req_if.sink                    in_if,
  orb_rsp_if.source                  out_if,
  input  logic                       cfg_wr_en,
  input  logic [orb_pkg::CNT_W-1:0]  cfg_wr_data
);
  import orb_pkg::*;

  orb_cmd_t cmd;
  orb_sts_t sts;

  orb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  orb_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_type     (in_if.req_type),
    .value        (in_if.value),
    .remove_count (in_if.remove_count),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .sts          (sts),
    .out_if       (out_if)
  );

endmodule
